[src/deve_pkg.sv]
// shared types and constants of the dex encoded value encoder
`default_nettype none
package deve_pkg;

	localparam int unsigned MaxBytes = 10;
	localparam int unsigned LenW     = $clog2(MaxBytes + 1);
	localparam int unsigned PosW     = $clog2(MaxBytes);

	typedef enum logic [3:0] {
		KIND_BYTE   = 4'd0,
		KIND_SHORT  = 4'd1,
		KIND_CHAR   = 4'd2,
		KIND_INT    = 4'd3,
		KIND_LONG   = 4'd4,
		KIND_FLOAT  = 4'd5,
		KIND_DOUBLE = 4'd6,
		KIND_STRING = 4'd7,
		KIND_TYPE   = 4'd8,
		KIND_ENUM   = 4'd9,
		KIND_NULL   = 4'd10,
		KIND_BOOL   = 4'd11,
		KIND_ANNOT  = 4'd12,
		KIND_NAME   = 4'd13
	} kind_t;

	// value type codes and fixed header bytes
	localparam logic [7:0] HdrByte     = 8'h00;
	localparam logic [7:0] HdrShort    = 8'h22;
	localparam logic [7:0] HdrChar     = 8'h23;
	localparam logic [4:0] VtInt       = 5'h04;
	localparam logic [4:0] VtLong      = 5'h06;
	localparam logic [7:0] HdrFloat    = 8'h70;
	localparam logic [7:0] HdrDouble   = 8'hF1;
	localparam logic [4:0] VtString    = 5'h17;
	localparam logic [4:0] VtType      = 5'h18;
	localparam logic [4:0] VtEnum      = 5'h1B;
	localparam logic [7:0] HdrNull     = 8'h1E;
	localparam logic [7:0] HdrFalse    = 8'h1F;
	localparam logic [7:0] HdrTrue     = 8'h3F;
	localparam logic [7:0] HdrUnknown  = 8'h04;
	localparam logic [31:0] IdxMissing = 32'hFFFF_FFFF;

	// one classified item: its bytes and how many of them are sent
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [LenW-1:0]          len;
	} enc_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage
`default_nettype wire

[src/deve_item_if.sv]
// input item channel
`default_nettype none
interface deve_item_if;
	logic        valid;
	logic        ready;
	logic [3:0]  func;
	logic [63:0] value_bits;
	logic [31:0] index_value;
	logic [31:0] elem_total;

	modport source(output valid, func, value_bits, index_value, elem_total, input ready);
	modport sink(input valid, func, value_bits, index_value, elem_total, output ready);
endinterface
`default_nettype wire

[src/deve_byte_if.sv]
// output byte channel
`default_nettype none
interface deve_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;

	modport source(output valid, out_byte, last_byte, input ready);
	modport sink(input valid, out_byte, last_byte, output ready);
endinterface
`default_nettype wire

[src/deve_front.sv]
// front end: classifies an item and builds its byte image
`default_nettype none
module deve_front (
	input  wire logic [3:0]     func,
	input  wire logic [63:0]    value_bits,
	input  wire logic [31:0]    index_value,
	input  wire logic [31:0]    elem_total,
	output deve_pkg::enc_t      enc
);

	typedef struct packed {
		logic [4:0][7:0] bytes;
		logic [2:0]      len;
	} uleb_t;

	// fewest signed bytes that hold v
	function automatic logic [3:0] signed_size(input logic [63:0] v);
		logic [3:0]  n;
		logic [63:0] m;
		n = 4'd8;
		for (int k = 7; k >= 1; k--) begin
			m = {64{1'b1}} << (8 * k - 1);
			if ((v & m) == 64'd0 || (v & m) == m) begin
				n = 4'(k);
			end
		end
		return n;
	endfunction

	function automatic uleb_t uleb(input logic [31:0] x);
		uleb_t u;
		if (x[31:28] != 4'd0)      u.len = 3'd5;
		else if (x[27:21] != 7'd0) u.len = 3'd4;
		else if (x[20:14] != 7'd0) u.len = 3'd3;
		else if (x[13:7] != 7'd0)  u.len = 3'd2;
		else                       u.len = 3'd1;
		u.bytes[0] = {(u.len > 3'd1), x[6:0]};
		u.bytes[1] = {(u.len > 3'd2), x[13:7]};
		u.bytes[2] = {(u.len > 3'd3), x[20:14]};
		u.bytes[3] = {(u.len > 3'd4), x[27:21]};
		u.bytes[4] = {4'd0, x[31:28]};
		return u;
	endfunction

	logic [31:0] idx_fix;
	logic [63:0] int_ext;
	logic [3:0]  n_int;
	logic [3:0]  n_long;
	logic        idx_wide;
	logic [4:0]  vtype;
	uleb_t       u_idx;
	uleb_t       u_cnt;
	logic [deve_pkg::MaxBytes-1:0][7:0] annot_bytes;
	logic [3:0]  rel;

	assign idx_fix  = (index_value == deve_pkg::IdxMissing) ? 32'd0 : index_value;
	assign int_ext  = {{32{value_bits[31]}}, value_bits[31:0]};
	assign n_int    = signed_size(int_ext);
	assign n_long   = signed_size(value_bits);
	assign idx_wide = idx_fix[31:16] != 16'd0;
	assign u_idx    = uleb(idx_fix);
	assign u_cnt    = uleb(elem_total);

	always_comb begin
		unique case (func)
			deve_pkg::KIND_TYPE: vtype = deve_pkg::VtType;
			deve_pkg::KIND_ENUM: vtype = deve_pkg::VtEnum;
			default:             vtype = deve_pkg::VtString;
		endcase
	end

	// index uleb followed by count uleb
	always_comb begin
		rel = 4'd0;
		for (int j = 0; j < deve_pkg::MaxBytes; j++) begin
			rel = 4'(j) - {1'b0, u_idx.len};
			if (4'(j) < {1'b0, u_idx.len}) begin
				annot_bytes[j] = u_idx.bytes[j % 5];
			end else if (rel < 4'd5) begin
				annot_bytes[j] = u_cnt.bytes[rel[2:0]];
			end else begin
				annot_bytes[j] = 8'h00;
			end
		end
	end

	always_comb begin
		enc.bytes = '0;
		for (int k = 0; k < 8; k++) begin
			enc.bytes[k+1] = value_bits[8*k +: 8];
		end
		enc.len = deve_pkg::LenW'(2);
		unique case (func)
			deve_pkg::KIND_BYTE: begin
				enc.bytes[0] = deve_pkg::HdrByte;
			end
			deve_pkg::KIND_SHORT: begin
				enc.bytes[0] = deve_pkg::HdrShort;
				enc.len      = deve_pkg::LenW'(3);
			end
			deve_pkg::KIND_CHAR: begin
				enc.bytes[0] = deve_pkg::HdrChar;
				enc.len      = deve_pkg::LenW'(3);
			end
			deve_pkg::KIND_INT: begin
				for (int k = 0; k < 8; k++) begin
					enc.bytes[k+1] = int_ext[8*k +: 8];
				end
				enc.bytes[0] = {3'(n_int - 4'd1), deve_pkg::VtInt};
				enc.len      = deve_pkg::LenW'(n_int) + deve_pkg::LenW'(1);
			end
			deve_pkg::KIND_LONG: begin
				enc.bytes[0] = {3'(n_long - 4'd1), deve_pkg::VtLong};
				enc.len      = deve_pkg::LenW'(n_long) + deve_pkg::LenW'(1);
			end
			deve_pkg::KIND_FLOAT: begin
				enc.bytes[0] = deve_pkg::HdrFloat;
				enc.len      = deve_pkg::LenW'(5);
			end
			deve_pkg::KIND_DOUBLE: begin
				enc.bytes[0] = deve_pkg::HdrDouble;
				enc.len      = deve_pkg::LenW'(9);
			end
			deve_pkg::KIND_STRING, deve_pkg::KIND_TYPE, deve_pkg::KIND_ENUM: begin
				enc.bytes    = '0;
				enc.bytes[0] = {idx_wide ? 3'd2 : 3'd1, vtype};
				enc.bytes[1] = idx_fix[7:0];
				enc.bytes[2] = idx_fix[15:8];
				enc.bytes[3] = idx_fix[23:16];
				enc.len      = idx_wide ? deve_pkg::LenW'(4) : deve_pkg::LenW'(3);
			end
			deve_pkg::KIND_NULL: begin
				enc.bytes[0] = deve_pkg::HdrNull;
				enc.len      = deve_pkg::LenW'(1);
			end
			deve_pkg::KIND_BOOL: begin
				enc.bytes[0] = (value_bits != 64'd0) ? deve_pkg::HdrTrue : deve_pkg::HdrFalse;
				enc.len      = deve_pkg::LenW'(1);
			end
			deve_pkg::KIND_ANNOT: begin
				enc.bytes = annot_bytes;
				enc.len   = deve_pkg::LenW'(u_idx.len) + deve_pkg::LenW'(u_cnt.len);
			end
			deve_pkg::KIND_NAME: begin
				enc.bytes      = '0;
				enc.bytes[4:0] = u_idx.bytes;
				enc.len        = deve_pkg::LenW'(u_idx.len);
			end
			default: begin
				// unknown kind goes out as integer zero
				enc.bytes    = '0;
				enc.bytes[0] = deve_pkg::HdrUnknown;
			end
		endcase
	end

endmodule
`default_nettype wire

[src/deve_queue.sv]
// two-entry queue of classified items between front and back
`default_nettype none
module deve_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire deve_pkg::enc_t    wr_data,
	input  wire logic              pop,
	output deve_pkg::enc_t         head,
	output deve_pkg::q_stat_t      stat
);

	deve_pkg::enc_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.empty = count_q == 2'd0;
	assign stat.full  = count_q == 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

[src/deve_back.sv]
// back end: walks the head item byte by byte into the output register
`default_nettype none
module deve_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire deve_pkg::enc_t    head,
	input  wire deve_pkg::q_stat_t stat,
	output logic                   pop,
	deve_byte_if.source            stream
);

	logic [deve_pkg::PosW-1:0] pos_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       advance;
	logic       take;
	logic       at_end;

	assign advance = !valid_q || stream.ready;
	assign take    = advance && !stat.empty;
	assign at_end  = deve_pkg::LenW'(pos_q) == head.len - deve_pkg::LenW'(1);
	assign pop     = take && at_end;

	assign stream.valid     = valid_q;
	assign stream.out_byte  = byte_q;
	assign stream.last_byte = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= take;
			if (take) begin
				pos_q <= at_end ? '0 : pos_q + deve_pkg::PosW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= head.bytes[pos_q];
			last_q <= at_end;
		end
	end

endmodule
`default_nettype wire

[src/dex_encoded_value_encoder.sv]
// top level of the dex encoded value encoder
//
//  channel | dir | payload                                      | last beat
//  item    | in  | func, value_bits, index_value, elem_total     | every beat is one item
//  stream  | out | out_byte, last_byte                          | last_byte set
//
// an item is classified in the cycle it is accepted and parked in a two-entry queue;
// the back end sends one byte beat per cycle while the output is not stalled, so an
// item of n bytes (1 to 10) goes out as n beats. input is taken while the queue has a
// free entry. an item's first byte passes its queue entry, then the output register.
// arst_n clears the queue pointers, the byte counter and the output valid.
`default_nettype none
module dex_encoded_value_encoder (
	input  wire logic   clk,
	input  wire logic   arst_n,
	deve_item_if.sink   item,
	deve_byte_if.source stream
);

	deve_pkg::enc_t    enc;
	deve_pkg::enc_t    head;
	deve_pkg::q_stat_t stat;
	logic              push;
	logic              pop;

	assign item.ready = !stat.full;
	assign push       = item.valid && item.ready;

	deve_front u_front (
		.func        (item.func),
		.value_bits  (item.value_bits),
		.index_value (item.index_value),
		.elem_total  (item.elem_total),
		.enc         (enc)
	);

	deve_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (enc),
		.pop     (pop),
		.head    (head),
		.stat    (stat)
	);

	deve_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.stat   (stat),
		.pop    (pop),
		.stream (stream)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("queue popped while empty");

	a_stat_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.empty && stat.full))
		else $error("queue both empty and full");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && stat.empty) |=> !stat.empty)
		else $error("accepted item lost from queue");

	a_pop_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (stream.valid && stream.last_byte))
		else $error("item retired without a last beat");

endmodule
`default_nettype wire
